[hw/rtl/rdc_pkg.sv]
`timescale 1ns / 1ps

package rdc_pkg;

    localparam logic [4:0] RADIX_MIN  = 5'd2;
    localparam logic [4:0] RADIX_MAX  = 5'd16;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;   // "0"
    localparam logic [6:0] CHAR_A     = 7'h41;   // "A"
    localparam logic [6:0] CHAR_F     = 7'h46;   // "F"
    localparam logic [6:0] CHAR_NONE  = 7'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_STORE,
        ST_RD,
        ST_LOAD,
        ST_ERR
    } rdc_state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic rd_issue;
        logic out_digit;
        logic out_err;
    } rdc_cmd_t;

    typedef struct packed {
        logic bad_base;
        logic bit_done;
        logic more;
        logic rd_last;
        logic out_free;
    } rdc_sts_t;

    function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + {3'b000, d};
        end
        else
        begin
            c = CHAR_A + {3'b000, d} - 7'd10;
        end
        return c;
    endfunction

endpackage

[hw/rtl/rdc_if.sv]
`timescale 1ns / 1ps

interface rdc_in_if #(
    parameter int VALUE_BITS = 31
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic [4:0]            base;

    modport source (output valid, output value, output base, input ready);
    modport sink   (input valid, input value, input base, output ready);
endinterface

interface rdc_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] digit_char;
    logic       is_last;
    logic       bad_base;

    modport source (output valid, output digit_char, output is_last, output bad_base,
                    input ready);
    modport sink   (input valid, input digit_char, input is_last, input bad_base,
                    output ready);
endinterface

[hw/rtl/rdc_ram.sv]
`timescale 1ns / 1ps

module rdc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 31
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/rdc_ctrl.sv]
`timescale 1ns / 1ps

module rdc_ctrl
    import rdc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rdc_sts_t sts,
    output rdc_cmd_t cmd
);

    rdc_state_t state_reg;
    rdc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.bad_base ? ST_ERR : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.bit_done)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                state_next = sts.more ? ST_DIV : ST_RD;
            end
            ST_RD:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = sts.rd_last ? ST_IDLE : ST_RD;
            end
            ST_ERR:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
            end
            ST_RD:
            begin
                cmd.rd_issue = sts.out_free;
            end
            ST_LOAD:
            begin
                cmd.out_digit = 1'b1;
            end
            ST_ERR:
            begin
                cmd.out_err = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[hw/rtl/rdc_dp.sv]
`timescale 1ns / 1ps

module rdc_dp
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = 31,
    parameter int MAX_DIGITS = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic [4:0]            in_base,
    input  rdc_cmd_t              cmd,
    output rdc_sts_t              sts,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [6:0]            out_digit_char,
    output logic                  out_is_last,
    output logic                  out_bad_base
);

    localparam int ADDR_W = $clog2(MAX_DIGITS);
    localparam int BC_W   = $clog2(VALUE_BITS);
    localparam logic [ADDR_W-1:0] IDX_TOP  = ADDR_W'(MAX_DIGITS - 1);
    localparam logic [BC_W-1:0]   BIT_LAST = BC_W'(VALUE_BITS - 1);

    logic [VALUE_BITS-1:0] quot_reg,  quot_next;
    logic [3:0]            rem_reg,   rem_next;
    logic [4:0]            base_reg,  base_next;
    logic [BC_W-1:0]       bitcnt_reg, bitcnt_next;
    logic [ADDR_W-1:0]     idx_reg,   idx_next;
    logic                  rd_last_reg, rd_last_next;
    logic                  out_valid_reg, out_valid_next;
    logic [6:0]            char_reg,  char_next;
    logic                  last_reg,  last_next;
    logic                  bad_reg,   bad_next;

    logic [4:0] rem_shift;
    logic [4:0] rem_diff;
    logic       qbit;
    logic       more;
    logic [3:0] ram_rd_data;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign rem_diff  = rem_shift - base_reg;
    assign qbit      = (rem_shift >= base_reg);
    assign more      = (quot_reg != '0) && (idx_reg != IDX_TOP);

    assign sts.bad_base = (in_base < RADIX_MIN) || (in_base > RADIX_MAX);
    assign sts.bit_done = (bitcnt_reg == BIT_LAST);
    assign sts.more     = more;
    assign sts.rd_last  = rd_last_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    rdc_ram #(
        .WIDTH (4),
        .DEPTH (MAX_DIGITS)
    ) u_digit_store (
        .clk     (clk),
        .wr_en   (cmd.store),
        .wr_addr (idx_reg),
        .wr_data (rem_reg),
        .rd_en   (cmd.rd_issue),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        base_next    = base_reg;
        bitcnt_next  = bitcnt_reg;
        idx_next     = idx_reg;
        rd_last_next = rd_last_reg;
        if (cmd.load)
        begin
            quot_next   = in_value;
            rem_next    = 4'd0;
            base_next   = in_base;
            bitcnt_next = '0;
            idx_next    = '0;
        end
        if (cmd.div_step)
        begin
            quot_next   = {quot_reg[VALUE_BITS-2:0], qbit};
            rem_next    = qbit ? rem_diff[3:0] : rem_shift[3:0];
            bitcnt_next = bitcnt_reg + 1'b1;
        end
        if (cmd.store)
        begin
            rem_next    = 4'd0;
            bitcnt_next = '0;
            if (more)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (cmd.rd_issue)
        begin
            rd_last_next = (idx_reg == '0);
            if (idx_reg != '0)
            begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_digit)
        begin
            out_valid_next = 1'b1;
            char_next      = digit_to_ascii(ram_rd_data);
            last_next      = rd_last_reg;
            bad_next       = 1'b0;
        end
        if (cmd.out_err)
        begin
            out_valid_next = 1'b1;
            char_next      = CHAR_NONE;
            last_next      = 1'b1;
            bad_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitcnt_reg    <= '0;
            idx_reg       <= '0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            quot_reg      <= '0;
        end
        else
        begin
            bitcnt_reg    <= bitcnt_next;
            idx_reg       <= idx_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
            quot_reg      <= quot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        base_reg <= base_next;
        char_reg <= char_next;
        last_reg <= last_next;
        bad_reg  <= bad_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_digit_char = char_reg;
    assign out_is_last    = last_reg;
    assign out_bad_base   = bad_reg;

    // never overwrite a result that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_digit || cmd.out_err) |-> (!out_valid_reg || out_ready))
    else $error("result register overwritten while held");

    // dividing only runs with a legal radix
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (base_reg >= RADIX_MIN) && (base_reg <= RADIX_MAX))
    else $error("division step with radix outside range");

    // remainder stays below the radix during a division
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> ({1'b0, rem_reg} < base_reg))
    else $error("remainder not reduced below radix");

    // an error result is always flagged last and carries no character
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && bad_reg) |-> (last_reg && (char_reg == CHAR_NONE)))
    else $error("malformed error result");

    // a digit result carries a legal digit character
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !bad_reg) |-> ((char_reg >= CHAR_ZERO) && (char_reg <= CHAR_F)))
    else $error("digit character out of range");

endmodule

[hw/rtl/radix_digit_converter_unit.sv]
`timescale 1ns / 1ps
// Accepting an item loads the value and radix; then each digit is found by
// bit-serial restoring division (one quotient bit per cycle), stored, and later emitted
// through the registered digit store read, most significant digit first.
// Throughput: one item at a time; the next is taken once the last digit is loaded
// into the output register. Output stalls lengthen the emit phase. A bad radix goes to
// the error state, which gives one result once the output is free. Reset (rst_n, async) idles.
module radix_digit_converter_unit
    import rdc_pkg::*;
#(
    parameter int VALUE_BITS = 31,
    parameter int MAX_DIGITS = 31
) (
    input  logic      clk,
    input  logic      rst_n,
    rdc_in_if.sink    in_ch,
    rdc_out_if.source out_ch
);

    rdc_cmd_t cmd;
    rdc_sts_t sts;

    rdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rdc_dp #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_value       (in_ch.value),
        .in_base        (in_ch.base),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_digit_char (out_ch.digit_char),
        .out_is_last    (out_ch.is_last),
        .out_bad_base   (out_ch.bad_base)
    );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import rdc_pkg::*;

    localparam int VALUE_BITS  = 31;
    localparam int MAX_DIGITS  = 31;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 2 * (1 + MAX_DIGITS * (VALUE_BITS + 3));

    typedef struct packed {
        logic [6:0] digit_char;
        logic       is_last;
        logic       bad_base;
    } digit_result_t;

    logic clk;
    logic rst_n;

    digit_result_t   pending_digits[$];
    int              mismatch_count;
    int              cycle_count;
    bit              steady;

    rdc_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch();
    rdc_out_if                           out_ch();

    radix_digit_converter_unit #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d digits outstanding",
                     cycle_count, pending_digits.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Work out the digit characters a conversion must produce, most significant first.
    task automatic predict_digits(input logic [VALUE_BITS-1:0] value, input logic [4:0] base);
        logic [3:0]      remainders[MAX_DIGITS];
        longint unsigned quotient;
        int              count;
        digit_result_t   r;
        if (base < RADIX_MIN || base > RADIX_MAX)
        begin
            r.digit_char = CHAR_NONE;
            r.is_last    = 1'b1;
            r.bad_base   = 1'b1;
            pending_digits.push_back(r);
            return;
        end
        quotient = value;
        count    = 0;
        do
        begin
            remainders[count] = 4'(quotient % base);
            quotient          = quotient / base;
            count++;
        end
        while (quotient > 0 && count < MAX_DIGITS);
        for (int k = count - 1; k >= 0; k--)
        begin
            if (remainders[k] < 4'd10)
                r.digit_char = CHAR_ZERO + 7'(remainders[k]);
            else
                r.digit_char = CHAR_A + 7'(remainders[k] - 4'd10);
            r.is_last  = (k == 0);
            r.bad_base = 1'b0;
            pending_digits.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("[%0t] %s mismatch: got %0d, expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic send_number(input logic [VALUE_BITS-1:0] value, input logic [4:0] base);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid = 1'b0;
            in_ch.value = VALUE_BITS'($urandom);
            in_ch.base  = 5'($urandom);
        end
        @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.value = value;
        in_ch.base  = base;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_digits(value, base);
    endtask

    function automatic logic [VALUE_BITS-1:0] random_value();
        int          w;
        logic [31:0] v;
        w = $urandom_range(1, VALUE_BITS);
        v = $urandom & ((32'h1 << w) - 32'h1);
        return VALUE_BITS'(v);
    endfunction

    function automatic logic [4:0] random_bad_base();
        logic [4:0] b;
        b = 5'($urandom_range(0, 16));
        // fold the draw onto 0, 1 and 17..31
        if (b < 5'd2)
            return b;
        return b + 5'd15;
    endfunction

    task automatic test_extremes();
        logic [VALUE_BITS-1:0] all_ones;
        all_ones = '1;
        send_number('0, RADIX_MIN);
        send_number('0, RADIX_MAX);
        send_number(all_ones, RADIX_MIN);
        send_number(all_ones, RADIX_MAX);
        send_number(all_ones, 5'd10);
        send_number(all_ones, 5'd3);
        send_number(all_ones, 5'd7);
        send_number(1, RADIX_MIN);
        send_number(15, RADIX_MAX);
        send_number(16, RADIX_MAX);
        send_number(255, RADIX_MAX);
        send_number(10, 5'd10);
        send_number(64, 5'd8);
        send_number(VALUE_BITS'(32'h2AAA_AAAA), 5'd4);
    endtask

    task automatic test_bad_bases();
        send_number(random_value(), 5'd0);
        send_number(random_value(), 5'd1);
        send_number('0, 5'd17);
        send_number('1, 5'd24);
        send_number(random_value(), 5'd31);
    endtask

    task automatic test_random_numbers(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 15)
                send_number(random_value(), random_bad_base());
            else
                send_number(random_value(), 5'($urandom_range(2, 16)));
        end
    endtask

    task automatic test_back_to_back(input int count);
        steady = 1'b1;
        test_random_numbers(count);
        steady = 1'b0;
    endtask

    // Drive ready with random stalls between transactions, except while steady is set.
    initial
    begin : result_sink
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 10);
            repeat (stall)
            begin
                @(negedge clk);
                out_ch.ready = 1'b0;
            end
            @(negedge clk);
            out_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        digit_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_digits.size() == 0)
            begin
                report_mismatch("unexpected transaction, digit_char", out_ch.digit_char, 0);
            end
            else
            begin
                want = pending_digits.pop_front();
                if (out_ch.digit_char !== want.digit_char)
                    report_mismatch("digit_char", out_ch.digit_char, want.digit_char);
                if (out_ch.is_last !== want.is_last)
                    report_mismatch("is_last", out_ch.is_last, want.is_last);
                if (out_ch.bad_base !== want.bad_base)
                    report_mismatch("bad_base", out_ch.bad_base, want.bad_base);
            end
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        steady         = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        in_ch.valid    = 1'b0;
        in_ch.value    = '0;
        in_ch.base     = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_bad_bases();
        test_random_numbers(120);
        test_back_to_back(30);

        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
        // hold a while longer to catch stray transactions
        repeat (SETTLE) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
